// File: src/rgb_to_hsv_pixel_defines.svh
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_defines.svh
// Assertion macros for the RGB to HSV converter's divider.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// Same-cycle implication.
`define RTH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// Widths, the divider stage record and the one-bit restoring divide step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

  localparam int CH_BITS    = 16;
  // divisor range must cover 6 * chroma
  localparam int DIV_W      = CH_BITS + 3;
  localparam int DIV_STAGES = CH_BITS;

  typedef logic [CH_BITS-1:0] chan_t;
  typedef logic [DIV_W-1:0]   dval_t;

  // One request in flight through the divider: saturation and hue side by side.
  typedef struct packed {
    dval_t s_rem;
    dval_t s_den;
    chan_t s_low;
    chan_t s_quo;
    dval_t h_rem;
    dval_t h_den;
    chan_t h_quo;
    chan_t bright;
  } div_t;

  // One quotient bit for each divide. Remainders stay below their divisors.
  function automatic div_t div_step(div_t x);
    logic [DIV_W:0] s_sh;
    logic [DIV_W:0] h_sh;
    logic [DIV_W:0] s_dif;
    logic [DIV_W:0] h_dif;
    logic           s_ge;
    logic           h_ge;
    div_t           y;
    y     = x;
    s_sh  = {x.s_rem, x.s_low[CH_BITS-1]};
    h_sh  = {x.h_rem, 1'b0};
    s_dif = s_sh - {1'b0, x.s_den};
    h_dif = h_sh - {1'b0, x.h_den};
    s_ge  = (s_sh >= {1'b0, x.s_den});
    h_ge  = (h_sh >= {1'b0, x.h_den});
    y.s_rem = s_ge ? s_dif[DIV_W-1:0] : s_sh[DIV_W-1:0];
    y.h_rem = h_ge ? h_dif[DIV_W-1:0] : h_sh[DIV_W-1:0];
    y.s_low = {x.s_low[CH_BITS-2:0], 1'b0};
    y.s_quo = {x.s_quo[CH_BITS-2:0], s_ge};
    y.h_quo = {x.h_quo[CH_BITS-2:0], h_ge};
    return y;
  endfunction

endpackage

`default_nettype wire

// File: src/rgb_to_hsv_pixel.sv
// Pipeline: an accepted rgb request passes 3 front stages for max/min, chroma and
// numerators, then 16 divider stages, one quotient bit each, to hsv_valid.
// Throughput: one pixel per clock unless hsv_ready stalls the output; every stage
// holds a valid bit and empty stages fill even while the output is stalled.
// Reset (rst, synchronous) clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// Converts one RGB pixel to hue, saturation and brightness per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_pixel (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           rgb_valid,
  output logic                rgb_ready,
  input  wire rth_pkg::chan_t red,
  input  wire rth_pkg::chan_t green,
  input  wire rth_pkg::chan_t blue,
  output logic                hsv_valid,
  input  wire logic           hsv_ready,
  output rth_pkg::chan_t      hue,
  output rth_pkg::chan_t      saturation,
  output rth_pkg::chan_t      brightness
);
  import rth_pkg::*;

  logic mid_valid;
  logic mid_ready;
  div_t mid_data;

  rth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rgb_valid),
    .in_ready  (rgb_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  rth_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (mid_valid),
    .in_ready   (mid_ready),
    .in_data    (mid_data),
    .out_valid  (hsv_valid),
    .out_ready  (hsv_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

endmodule

`default_nettype wire

// File: src/rth_front.sv
// ----------------------------------------------------------------------------
// rth_front
// Three stages: max/min and sector, chroma and channel difference, then
// hue numerator, 6 * chroma and the saturation dividend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rth_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rth_pkg::chan_t red,
  input  wire rth_pkg::chan_t green,
  input  wire rth_pkg::chan_t blue,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rth_pkg::div_t       out_data
);
  import rth_pkg::*;

  typedef enum logic [1:0] {SECT_RED, SECT_GREEN, SECT_BLUE} sector_t;

  logic    s1_valid;
  chan_t   s1_v;
  chan_t   s1_mn;
  chan_t   s1_r;
  chan_t   s1_g;
  chan_t   s1_b;
  sector_t s1_sect;

  logic                 s2_valid;
  chan_t                s2_v;
  chan_t                s2_c;
  logic signed [CH_BITS:0] s2_d;
  sector_t              s2_sect;

  logic mv1;
  logic mv2;
  logic mv3;

  chan_t   v_next;
  chan_t   mn_next;
  sector_t sect_next;

  logic signed [CH_BITS:0] d_next;

  dval_t                c_ext;
  dval_t                c6;
  dval_t                base;
  dval_t                num;
  logic [2*CH_BITS-1:0] sprod;
  div_t                 data_next;

  assign mv3      = !out_valid || out_ready;
  assign mv2      = !s2_valid || mv3;
  assign mv1      = !s1_valid || mv2;
  assign in_ready = mv1;

  // stage 1: brightness, darkest channel, sector (red wins ties, then green)
  always_comb begin
    v_next  = (red > green) ? red : green;
    v_next  = (v_next > blue) ? v_next : blue;
    mn_next = (red < green) ? red : green;
    mn_next = (mn_next < blue) ? mn_next : blue;
    if (v_next == red) begin
      sect_next = SECT_RED;
    end else if (v_next == green) begin
      sect_next = SECT_GREEN;
    end else begin
      sect_next = SECT_BLUE;
    end
  end

  // stage 2: the difference that sets the position inside the sector
  always_comb begin
    unique case (s1_sect)
      SECT_RED:   d_next = $signed({1'b0, s1_g}) - $signed({1'b0, s1_b});
      SECT_GREEN: d_next = $signed({1'b0, s1_b}) - $signed({1'b0, s1_r});
      SECT_BLUE:  d_next = $signed({1'b0, s1_r}) - $signed({1'b0, s1_g});
      default:    d_next = '0;
    endcase
  end

  // stage 3: N = sector offset + d (wrapped), dividend c * full-scale
  always_comb begin
    c_ext = dval_t'(s2_c);
    c6    = (c_ext << 2) + (c_ext << 1);
    unique case (s2_sect)
      SECT_RED:   base = s2_d[CH_BITS] ? c6 : '0;
      SECT_GREEN: base = c_ext << 1;
      SECT_BLUE:  base = c_ext << 2;
      default:    base = '0;
    endcase
    num   = base + {{(DIV_W-CH_BITS-1){s2_d[CH_BITS]}}, s2_d};
    sprod = {s2_c, {CH_BITS{1'b0}}} - {{CH_BITS{1'b0}}, s2_c};

    data_next.s_rem  = dval_t'(sprod[2*CH_BITS-1:CH_BITS]);
    data_next.s_low  = sprod[CH_BITS-1:0];
    // an all-ones divisor on black pixels (saturation) or black or gray pixels (hue) drives the quotient to zero
    data_next.s_den  = (s2_v == '0) ? '1 : dval_t'(s2_v);
    data_next.s_quo  = '0;
    data_next.h_rem  = num;
    data_next.h_den  = (s2_c == '0) ? '1 : c6;
    data_next.h_quo  = '0;
    data_next.bright = s2_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mv1) begin
        s1_valid <= in_valid;
      end
      if (mv2) begin
        s2_valid <= s1_valid;
      end
      if (mv3) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv1 && in_valid) begin
      s1_v    <= v_next;
      s1_mn   <= mn_next;
      s1_r    <= red;
      s1_g    <= green;
      s1_b    <= blue;
      s1_sect <= sect_next;
    end
    if (mv2 && s1_valid) begin
      s2_v    <= s1_v;
      s2_c    <= s1_v - s1_mn;
      s2_d    <= d_next;
      s2_sect <= s1_sect;
    end
    if (mv3 && s2_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: src/rth_divider.sv
// ----------------------------------------------------------------------------
// rth_divider
// Pipelined restoring divider, one quotient bit per stage, saturation and
// hue divides running in lockstep. Bubbles collapse under backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_pixel_defines.svh"

module rth_divider (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rth_pkg::div_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rth_pkg::chan_t     hue,
  output rth_pkg::chan_t     saturation,
  output rth_pkg::chan_t     brightness
);
  import rth_pkg::*;

  localparam int LAST = DIV_STAGES - 1;

  div_t                  st  [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES-1:0] mv;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    mv[LAST] = !vld[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      mv[k] = !vld[k] || mv[k+1];
    end
  end

  assign in_ready = mv[0];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic src_valid;
    div_t src_data;

    if (k == 0) begin : g_head
      assign src_valid = in_valid;
      assign src_data  = in_data;
    end else begin : g_body
      assign src_valid = vld[k-1];
      assign src_data  = st[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (mv[k]) begin
        vld[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (mv[k] && src_valid) begin
        st[k] <= div_step(src_data);
      end
    end
  end

  assign out_valid  = vld[LAST];
  assign hue        = st[LAST].h_quo;
  assign saturation = st[LAST].s_quo;
  assign brightness = st[LAST].bright;

  `RTH_ASSERT_NOW(a_sat_rem, clk, rst, vld[LAST], st[LAST].s_rem < st[LAST].s_den, "saturation remainder not below divisor")
  `RTH_ASSERT_NOW(a_hue_rem, clk, rst, vld[LAST], st[LAST].h_rem < st[LAST].h_den, "hue remainder not below divisor")
  `RTH_ASSERT_NEXT(a_enter, clk, rst, in_valid && in_ready, vld[0], "accepted request missing from first stage")
  `RTH_ASSERT_NEXT(a_hold, clk, rst, vld[0] && !mv[0], vld[0] && $stable(st[0]), "stalled first stage changed")

endmodule

`default_nettype wire
